@@ hdl/sip_pkg.sv @@
`timescale 1ns / 1ps
package sip_pkg;

  localparam int DEF_COMPRESS_ROUNDS = 2;
  localparam int DEF_FINAL_ROUNDS    = 4;
  localparam int DEF_QUEUE_DEPTH     = 2;

  localparam logic [63:0] INIT_V0  = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_V1  = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_V2  = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_V3  = 64'h7465646279746573;
  localparam logic [63:0] FIN_FLIP = 64'h00000000000000ff;

  localparam int          CFG_ADDR_W   = 2;
  localparam logic [1:0]  REG_KEY_LOW  = 2'd0;
  localparam logic [1:0]  REG_KEY_HIGH = 2'd1;
  localparam logic [1:0]  REG_FOLD     = 2'd2;

  localparam logic [3:0]  FULL_BYTES = 4'd8;

  // block kinds handed from front to back
  localparam logic [1:0] OP_ABSORB    = 2'd0;
  localparam logic [1:0] OP_FIN_SHORT = 2'd1;
  localparam logic [1:0] OP_FIN_FULL  = 2'd2;

  typedef struct packed {
    logic        wr_low;
    logic        wr_high;
    logic        wr_fold;
    logic [63:0] data;
  } sip_cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] data;
    logic [7:0]  len;
  } sip_op_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  function automatic sip_state_t sip_init(input logic [63:0] k0, input logic [63:0] k1);
    sip_state_t s;
    s.v0 = INIT_V0 ^ k0;
    s.v1 = INIT_V1 ^ k1;
    s.v2 = INIT_V2 ^ k0;
    s.v3 = INIT_V3 ^ k1;
    return s;
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    logic [63:0] a0;
    logic [63:0] a1;
    logic [63:0] a2;
    logic [63:0] a3;
    sip_state_t  r;
    a0 = s.v0 + s.v1;
    a1 = {s.v1[50:0], s.v1[63:51]} ^ a0;
    a0 = {a0[31:0], a0[63:32]};
    a2 = s.v2 + s.v3;
    a3 = {s.v3[47:0], s.v3[63:48]} ^ a2;
    a0 = a0 + a3;
    a3 = {a3[42:0], a3[63:43]} ^ a0;
    a2 = a2 + a1;
    a1 = {a1[46:0], a1[63:47]} ^ a2;
    a2 = {a2[31:0], a2[63:32]};
    r.v0 = a0;
    r.v1 = a1;
    r.v2 = a2;
    r.v3 = a3;
    return r;
  endfunction

  // keep the first cnt bytes, zero the rest
  function automatic logic [63:0] mask_bytes(input logic [63:0] w, input logic [3:0] cnt);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = (4'(i) < cnt) ? w[8*i +: 8] : 8'h00;
    end
    return r;
  endfunction

  // ascii upper case to lower case, byte by byte
  function automatic logic [63:0] lower_bytes(input logic [63:0] w);
    logic [63:0] r;
    logic [7:0]  b;
    for (int i = 0; i < 8; i++) begin
      b = w[8*i +: 8];
      r[8*i +: 8] = (b >= 8'h41 && b <= 8'h5a) ? (b + 8'h20) : b;
    end
    return r;
  endfunction

endpackage

@@ hdl/sip_front.sv @@
`timescale 1ns / 1ps
module sip_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sip_pkg::sip_cfg_t cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       word_data,
  input  logic [3:0]        word_bytes,
  input  logic              last_word,
  input  logic              q_full,
  output logic              push,
  output sip_pkg::sip_op_t  push_op
);
  import sip_pkg::*;

  logic        fold_r, fold_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [3:0]  cnt;
  logic [63:0] masked;
  logic [63:0] folded;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    cnt    = last_word ? ((word_bytes > FULL_BYTES) ? FULL_BYTES : word_bytes) : FULL_BYTES;
    masked = mask_bytes(word_data, cnt);
    folded = fold_r ? lower_bytes(masked) : masked;
    push_op.data = folded;
    push_op.len  = len_r + {4'd0, cnt};
    if (!last_word) begin
      push_op.op = OP_ABSORB;
    end else if (cnt == FULL_BYTES) begin
      push_op.op = OP_FIN_FULL;
    end else begin
      push_op.op = OP_FIN_SHORT;
    end
  end

  always_comb begin
    fold_nxt = cfg.wr_fold ? cfg.data[0] : fold_r;
    len_nxt  = len_r;
    if (push) begin
      len_nxt = last_word ? 8'd0 : push_op.len;
    end
    if (cfg.wr_low || cfg.wr_high) begin
      len_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r <= 1'b0;
      len_r  <= 8'd0;
    end else begin
      fold_r <= fold_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

@@ hdl/sip_queue.sv @@
`timescale 1ns / 1ps
module sip_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sip_pkg::sip_op_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output sip_pkg::sip_op_t rdata
);
  import sip_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sip_op_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ hdl/sip_back.sv @@
`timescale 1ns / 1ps
module sip_back #(
  parameter int COMPRESS_ROUNDS = sip_pkg::DEF_COMPRESS_ROUNDS,
  parameter int FINAL_ROUNDS    = sip_pkg::DEF_FINAL_ROUNDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sip_pkg::sip_cfg_t cfg,
  input  logic              q_valid,
  input  sip_pkg::sip_op_t  q_op,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       hash_value
);
  import sip_pkg::*;

  localparam int MAXR  = (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS : FINAL_ROUNDS;
  localparam int RND_W = $clog2(MAXR + 1);

  localparam logic [1:0] SEG_IDLE = 2'd0;
  localparam logic [1:0] SEG_ABS  = 2'd1;
  localparam logic [1:0] SEG_FIN  = 2'd2;

  logic [1:0]       seg_r, seg_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [63:0]      m_r, m_nxt;
  logic [63:0]      m2_r, m2_nxt;
  logic             m2_pend_r, m2_pend_nxt;
  logic             fin_pend_r, fin_pend_nxt;
  logic [63:0]      klow_r, klow_nxt;
  logic [63:0]      khigh_r, khigh_nxt;
  sip_state_t       v_r, v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_hash_r, out_hash_nxt;

  sip_state_t rin;
  sip_state_t rout;
  logic       first_rnd;
  logic       abs_last;
  logic       fin_last;
  logic       stall;
  logic       advance;
  logic       op_done;
  logic       fin_done;

  assign out_tvalid = out_valid_r;
  assign hash_value = out_hash_r;

  // shared round unit: message xor into v3 and the final flip of v2 ride on round zero
  always_comb begin
    first_rnd = (rnd_r == '0);
    rin       = v_r;
    if (seg_r == SEG_ABS && first_rnd) begin
      rin.v3 = v_r.v3 ^ m_r;
    end
    if (seg_r == SEG_FIN && first_rnd) begin
      rin.v2 = v_r.v2 ^ FIN_FLIP;
    end
    rout = sip_round(rin);
  end

  always_comb begin
    abs_last = (seg_r == SEG_ABS) && (rnd_r == RND_W'(COMPRESS_ROUNDS - 1));
    fin_last = (seg_r == SEG_FIN) && (rnd_r == RND_W'(FINAL_ROUNDS - 1));
    stall    = fin_last && out_valid_r && !out_tready;
    advance  = (seg_r != SEG_IDLE) && !stall;
    fin_done = fin_last && !stall;
    op_done  = (abs_last && !m2_pend_r && !fin_pend_r) || fin_done;
    pop      = q_valid && ((seg_r == SEG_IDLE) || op_done);
  end

  always_comb begin
    seg_nxt       = seg_r;
    rnd_nxt       = rnd_r;
    m_nxt         = m_r;
    m2_nxt        = m2_r;
    m2_pend_nxt   = m2_pend_r;
    fin_pend_nxt  = fin_pend_r;
    klow_nxt      = cfg.wr_low  ? cfg.data : klow_r;
    khigh_nxt     = cfg.wr_high ? cfg.data : khigh_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (advance) begin
      v_nxt   = rout;
      rnd_nxt = rnd_r + 1'b1;
      if (abs_last) begin
        v_nxt.v0 = rout.v0 ^ m_r;
        rnd_nxt  = '0;
        if (m2_pend_r) begin
          m_nxt       = m2_r;
          m2_pend_nxt = 1'b0;
        end else if (fin_pend_r) begin
          seg_nxt      = SEG_FIN;
          fin_pend_nxt = 1'b0;
        end else begin
          seg_nxt = SEG_IDLE;
        end
      end
      if (fin_last) begin
        seg_nxt       = SEG_IDLE;
        rnd_nxt       = '0;
        v_nxt         = sip_init(klow_r, khigh_r);
        out_valid_nxt = 1'b1;
        out_hash_nxt  = rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
      end
    end

    if (pop) begin
      seg_nxt = SEG_ABS;
      rnd_nxt = '0;
      case (q_op.op)
        OP_FIN_SHORT: begin
          m_nxt        = q_op.data | {q_op.len, 56'd0};
          m2_pend_nxt  = 1'b0;
          fin_pend_nxt = 1'b1;
        end
        OP_FIN_FULL: begin
          m_nxt        = q_op.data;
          m2_nxt       = {q_op.len, 56'd0};
          m2_pend_nxt  = 1'b1;
          fin_pend_nxt = 1'b1;
        end
        default: begin
          m_nxt        = q_op.data;
          m2_pend_nxt  = 1'b0;
          fin_pend_nxt = 1'b0;
        end
      endcase
    end

    // new key abandons any partial state
    if (cfg.wr_low || cfg.wr_high) begin
      v_nxt = sip_init(klow_nxt, khigh_nxt);
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    m2_r       <= m2_nxt;
    out_hash_r <= out_hash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= SEG_IDLE;
      rnd_r       <= '0;
      m2_pend_r   <= 1'b0;
      fin_pend_r  <= 1'b0;
      klow_r      <= 64'd0;
      khigh_r     <= 64'd0;
      v_r         <= sip_init(64'd0, 64'd0);
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      rnd_r       <= rnd_nxt;
      m2_pend_r   <= m2_pend_nxt;
      fin_pend_r  <= fin_pend_nxt;
      klow_r      <= klow_nxt;
      khigh_r     <= khigh_nxt;
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_r == SEG_IDLE) |-> (!m2_pend_r && !fin_pend_r))
    else $error("idle sequencer with blocks still pending");

  a_fin_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fin_done |=> out_valid_r)
    else $error("finalisation finished without a result");

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_valid && (seg_r == SEG_IDLE || op_done)))
    else $error("queue read while a block is in progress");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (stall && !cfg.wr_low && !cfg.wr_high) |=> ($stable(v_r) && seg_r == SEG_FIN))
    else $error("round state moved while the result was blocked");

endmodule

@@ hdl/siphash_2_4_keyed_hash_core.sv @@
`timescale 1ns / 1ps
// channel   dir   handshake              payload
// in_       in    in_tvalid/in_tready    in_tdata = word_data, word_bytes; in_tlast = last_word
// out_      out   out_tvalid/out_tready  out_tdata = hash_value
// cfg_      in    cfg_wr_en              cfg_addr (key_low, key_high, fold_case), cfg_data
//
// an inner word takes COMPRESS_ROUNDS SipRounds (2 by default), one SipRound a cycle on the
//   single round unit in the back part (a held result can stall it); the next word leaves the queue in its last round
// a last word under eight bytes takes COMPRESS_ROUNDS + FINAL_ROUNDS rounds (6), a full
//   last word 2 * COMPRESS_ROUNDS + FINAL_ROUNDS rounds (8); every word passes through the queue first
// reset is synchronous on rst_n low: keys and fold_case clear, the state loads from zero keys
// the front part takes words whenever the queue has room; a held result stalls only the last
//   finalisation round, the queue keeps filling meanwhile
module siphash_2_4_keyed_hash_core #(
  parameter int COMPRESS_ROUNDS = sip_pkg::DEF_COMPRESS_ROUNDS,
  parameter int FINAL_ROUNDS    = sip_pkg::DEF_FINAL_ROUNDS,
  parameter int QUEUE_DEPTH     = sip_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [sip_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                   cfg_data,
  // input words
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [71:0]                   in_tdata,   // [63:0] word_data, [67:64] word_bytes, [71:68] zero
  input  logic                          in_tlast,   // last_word
  // hash results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata   // [63:0] hash_value
);
  import sip_pkg::*;

  sip_cfg_t cfg;
  logic     push;
  sip_op_t  push_op;
  logic     q_full;
  logic     q_valid;
  logic     pop;
  sip_op_t  q_op;

  // register decode: an index beyond the list writes nothing
  always_comb begin
    cfg.wr_low  = cfg_wr_en && (cfg_addr == REG_KEY_LOW);
    cfg.wr_high = cfg_wr_en && (cfg_addr == REG_KEY_HIGH);
    cfg.wr_fold = cfg_wr_en && (cfg_addr == REG_FOLD);
    cfg.data    = cfg_data;
  end

  // front: masking, case folding, length byte and block kind
  sip_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .word_data  (in_tdata[63:0]),
    .word_bytes (in_tdata[67:64]),
    .last_word  (in_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  // short queue between classification and the round engine
  sip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_op),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .rdata (q_op)
  );

  // back: round sequencer, key state and result register
  sip_back #(
    .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
    .FINAL_ROUNDS    (FINAL_ROUNDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .hash_value (out_tdata)
  );

endmodule
